// ----- rtl/itm_trace_packet_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// itm trace packet decoder assertion macros
// shared property shorthands for the decoder checks
// ----------------------------------------------------------------------------
`ifndef ITM_TRACE_PACKET_DECODER_DEFINES_SVH
`define ITM_TRACE_PACKET_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ITM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ITM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/itmtpd_pkg.sv -----
// ----------------------------------------------------------------------------
// itm trace packet decoder package
// record layout, packet kinds, header codes and header classification
// ----------------------------------------------------------------------------
`default_nettype none

package itmtpd_pkg;

   // field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned MASK_W  = 32;
   localparam int unsigned VALUE_W = 42;
   localparam int unsigned TS_BITS = 7;

   // header codes
   localparam logic [7:0] OVERFLOW_HDR  = 8'h70;
   localparam logic [7:0] GTS_HDR_MASK  = 8'hDF;
   localparam logic [7:0] GTS_HDR_CODE  = 8'h94;
   localparam logic [7:0] LTS_SHORT_MSK = 8'h8F;
   localparam logic [7:0] PC_SLEEP_BYTE = 8'h00;
   localparam logic [7:0] PC_DENY_BYTE  = 8'hFF;

   // hardware source discriminators
   localparam logic [4:0] SRC_EVENT     = 5'd0;
   localparam logic [4:0] SRC_EXCEPTION = 5'd1;
   localparam logic [4:0] SRC_PC        = 5'd2;
   localparam logic [4:0] SRC_WATCH_LO  = 5'd8;
   localparam logic [4:0] SRC_WATCH_HI  = 5'd23;

   // global ts1 byte that carries the wrap and clock bits
   localparam logic [2:0] GTS1_META_BYTE = 3'd3;
   // last timestamp continuation byte position
   localparam logic [2:0] TS_LAST_BYTE   = 3'd5;

   typedef enum logic [3:0] {
      KIND_STIMULUS  = 4'd0,
      KIND_OVERFLOW  = 4'd1,
      KIND_LOCAL_TS  = 4'd2,
      KIND_GLOBAL_TS1 = 4'd3,
      KIND_GLOBAL_TS2 = 4'd4,
      KIND_PC        = 4'd5,
      KIND_SLEEP     = 4'd6,
      KIND_DENIED    = 4'd7,
      KIND_EVENT     = 4'd8,
      KIND_EXCEPTION = 4'd9,
      KIND_WATCH     = 4'd10
   } packet_kind_type;

   typedef enum logic [1:0] {
      FRAME_SINGLE   = 2'd0,
      FRAME_FIXED    = 2'd1,
      FRAME_VARIABLE = 2'd2
   } frame_type;

   typedef struct packed {
      logic [3:0]         packet_kind;
      logic [4:0]         port;
      logic [1:0]         comparator;
      logic [1:0]         watch_kind;
      logic [3:0]         exc_event;
      logic [VALUE_W-1:0] value;
      logic [2:0]         byte_count;
      logic [1:0]         stamp_meta;
   } result_type;

   // global timestamp header, either kind
   function automatic logic is_gts(input logic [7:0] h);
      return (h & GTS_HDR_MASK) == GTS_HDR_CODE;
   endfunction

   // framing class from the header byte
   function automatic frame_type frame_class(input logic [7:0] h);
      logic long_lts;
      long_lts = (h[3:0] == 4'd0) && (h[7:6] == 2'b11);
      if (h[1:0] != 2'd0) begin
         return FRAME_FIXED;
      end else if (long_lts || is_gts(h)) begin
         return FRAME_VARIABLE;
      end else begin
         return FRAME_SINGLE;
      end
   endfunction

   // payload length of a fixed frame: 1, 2 or 4 bytes
   function automatic logic [2:0] fixed_payload_bytes(input logic [1:0] lo);
      logic [2:0] len;
      case (lo)
         2'd1:    len = 3'd1;
         2'd2:    len = 3'd2;
         2'd3:    len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/itm_trace_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// itm trace packet decoder
// frames an itm/dwt trace byte stream and emits at most one record per packet
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_in_byte
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_packet_kind .. rsp_stamp_meta
//  csr     | in        | csr_valid/csr_ready  | csr_stimulus_port_mask
//
//  one trace byte per cycle unless a full result register is not drained; a
//  record is held in the single result register from the cycle after its last byte.
//  the result register is the only stage, so a byte is taken whenever that
//  register is empty or is being drained in the same cycle.
//  reset (synchronous) clears framing state, the port mask and the result valid flag.
//  csr writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "itm_trace_packet_decoder_defines.svh"

module itm_trace_packet_decoder
   import itmtpd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // trace byte input
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [BYTE_W-1:0]  req_in_byte,
   // packet records
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [3:0]         rsp_packet_kind,
   output      logic [4:0]         rsp_port,
   output      logic [1:0]         rsp_comparator,
   output      logic [1:0]         rsp_watch_kind,
   output      logic [3:0]         rsp_exc_event,
   output      logic [VALUE_W-1:0] rsp_value,
   output      logic [2:0]         rsp_byte_count,
   output      logic [1:0]         rsp_stamp_meta,
   // stimulus port mask register
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [MASK_W-1:0]  csr_stimulus_port_mask
);

   // registers
   logic [MASK_W-1:0]  mask_ff;
   logic [7:0]         frame_header_ff, frame_header_in;
   logic               frame_busy_ff, frame_busy_in;
   logic [2:0]         bytes_taken_ff, bytes_taken_in;
   logic [VALUE_W-1:0] accum_value_ff, accum_value_in;
   logic [1:0]         accum_meta_ff, accum_meta_in;
   result_type         rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic       req_fire;
   logic       res_valid;
   result_type res;

   // decode helpers
   logic [7:0]  b;
   logic [4:0]  src;
   frame_type   cur_class;
   logic [31:0] pay;
   logic [2:0]  count_next;
   logic [2:0]  plen;
   logic        hdr_gts;
   logic        hdr_gts2;
   logic        meta_byte;
   logic [6:0]  ts_bits;
   logic [VALUE_W-1:0] ts_ins;

   // check terms
   logic        fixed_busy;
   logic        ts_cap_fire;
   logic        exc_out;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign b          = req_in_byte;
   assign src        = frame_header_ff[7:3];
   assign cur_class  = frame_class(frame_header_ff);
   assign count_next = bytes_taken_ff + 3'd1;
   assign plen       = fixed_payload_bytes(frame_header_ff[1:0]);
   assign hdr_gts    = is_gts(frame_header_ff);
   assign hdr_gts2   = hdr_gts && frame_header_ff[5];
   assign meta_byte  = hdr_gts && !hdr_gts2 && (bytes_taken_ff == GTS1_META_BYTE);

   // fixed payload byte lands at its little-endian lane
   always_comb begin
      pay = accum_value_ff[31:0];
      case (bytes_taken_ff[1:0])
         2'd0:    pay[7:0]   = pay[7:0]   | b;
         2'd1:    pay[15:8]  = pay[15:8]  | b;
         2'd2:    pay[23:16] = pay[23:16] | b;
         2'd3:    pay[31:24] = pay[31:24] | b;
         default: pay = accum_value_ff[31:0];
      endcase
   end

   // timestamp continuation bits at 7-bit position
   assign ts_bits = meta_byte ? {2'b00, b[4:0]} : b[6:0];
   always_comb begin
      case (bytes_taken_ff)
         3'd0:    ts_ins = {35'd0, ts_bits};
         3'd1:    ts_ins = {28'd0, ts_bits, 7'd0};
         3'd2:    ts_ins = {21'd0, ts_bits, 14'd0};
         3'd3:    ts_ins = {14'd0, ts_bits, 21'd0};
         3'd4:    ts_ins = {7'd0, ts_bits, 28'd0};
         3'd5:    ts_ins = {ts_bits, 35'd0};
         default: ts_ins = '0;
      endcase
   end

   // framing and record decode
   always_comb begin
      frame_header_in = frame_header_ff;
      frame_busy_in   = frame_busy_ff;
      bytes_taken_in  = bytes_taken_ff;
      accum_value_in  = accum_value_ff;
      accum_meta_in   = accum_meta_ff;
      res             = '0;
      res_valid       = 1'b0;
      if (req_fire) begin
         if (!frame_busy_ff) begin
            // header byte
            frame_header_in = b;
            bytes_taken_in  = 3'd0;
            accum_value_in  = '0;
            accum_meta_in   = 2'd0;
            case (frame_class(b))
               FRAME_SINGLE: begin
                  if (b == OVERFLOW_HDR) begin
                     res.packet_kind = KIND_OVERFLOW;
                     res_valid       = 1'b1;
                  end else if (((b & LTS_SHORT_MSK) == 8'd0) && (b != 8'd0)) begin
                     res.packet_kind = KIND_LOCAL_TS;
                     res.value       = {{(VALUE_W-3){1'b0}}, b[6:4]};
                     res_valid       = 1'b1;
                  end
               end
               FRAME_VARIABLE: begin
                  if (!is_gts(b)) begin
                     accum_meta_in = b[5:4];
                  end
                  frame_busy_in = 1'b1;
               end
               default: begin
                  frame_busy_in = 1'b1;
               end
            endcase
         end else if (cur_class == FRAME_FIXED) begin
            // fixed-length payload byte
            accum_value_in = {{(VALUE_W-32){1'b0}}, pay};
            bytes_taken_in = count_next;
            if (count_next >= plen) begin
               frame_busy_in      = 1'b0;
               res.port           = src;
               res.value          = {{(VALUE_W-32){1'b0}}, pay};
               res.byte_count     = count_next;
               if (!frame_header_ff[2]) begin
                  res.packet_kind = KIND_STIMULUS;
                  res_valid       = mask_ff[src];
               end else if (src == SRC_PC) begin
                  if (count_next == 3'd4) begin
                     res.packet_kind = KIND_PC;
                     res_valid       = 1'b1;
                  end else if (count_next == 3'd1 && pay[7:0] == PC_SLEEP_BYTE) begin
                     res.packet_kind = KIND_SLEEP;
                     res_valid       = 1'b1;
                  end else if (count_next == 3'd1 && pay[7:0] == PC_DENY_BYTE) begin
                     res.packet_kind = KIND_DENIED;
                     res_valid       = 1'b1;
                  end
               end else if (src == SRC_EVENT) begin
                  res.packet_kind = KIND_EVENT;
                  res_valid       = (count_next == 3'd1);
               end else if (src == SRC_EXCEPTION) begin
                  res.packet_kind = KIND_EXCEPTION;
                  res.exc_event   = pay[15:12];
                  res.value       = {{(VALUE_W-9){1'b0}}, pay[8], pay[7:0]};
                  res_valid       = (count_next == 3'd2);
               end else if (src >= SRC_WATCH_LO && src <= SRC_WATCH_HI) begin
                  res.packet_kind = KIND_WATCH;
                  res.comparator  = src[2:1];
                  res.watch_kind  = {src[4], src[0]};
                  res_valid       = 1'b1;
               end
            end
         end else begin
            // timestamp continuation byte
            accum_value_in = accum_value_ff | ts_ins;
            bytes_taken_in = count_next;
            if (meta_byte) begin
               accum_meta_in = b[6:5];
            end
            if (!b[7] || bytes_taken_ff == TS_LAST_BYTE) begin
               frame_busy_in   = 1'b0;
               res.packet_kind = hdr_gts ? (hdr_gts2 ? KIND_GLOBAL_TS2 : KIND_GLOBAL_TS1)
                                         : KIND_LOCAL_TS;
               res.value       = accum_value_ff | ts_ins;
               res.byte_count  = count_next;
               res.stamp_meta  = meta_byte ? b[6:5] : accum_meta_ff;
               res_valid       = 1'b1;
            end
         end
      end
   end

   // result register occupancy
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = res_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff         <= '0;
         frame_header_ff <= '0;
         frame_busy_ff   <= 1'b0;
         bytes_taken_ff  <= '0;
         accum_value_ff  <= '0;
         accum_meta_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_stimulus_port_mask;
         end
         frame_header_ff <= frame_header_in;
         frame_busy_ff   <= frame_busy_in;
         bytes_taken_ff  <= bytes_taken_in;
         accum_value_ff  <= accum_value_in;
         accum_meta_ff   <= accum_meta_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, loaded on each transfer that yields a record
   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packet_kind = rsp_ff.packet_kind;
   assign rsp_port        = rsp_ff.port;
   assign rsp_comparator  = rsp_ff.comparator;
   assign rsp_watch_kind  = rsp_ff.watch_kind;
   assign rsp_exc_event   = rsp_ff.exc_event;
   assign rsp_value       = rsp_ff.value;
   assign rsp_byte_count  = rsp_ff.byte_count;
   assign rsp_stamp_meta  = rsp_ff.stamp_meta;

   // terms used by the checks
   assign fixed_busy  = frame_busy_ff && (cur_class == FRAME_FIXED);
   assign ts_cap_fire = req_fire && frame_busy_ff && (cur_class == FRAME_VARIABLE) &&
                        (bytes_taken_ff == TS_LAST_BYTE);
   assign exc_out     = rsp_valid_ff && (rsp_ff.packet_kind == KIND_EXCEPTION);

   // checks
   `ITM_ASSERT_SAME(a_fixed_count, fixed_busy, bytes_taken_ff < 3'd4, "fixed count too high")
   `ITM_ASSERT_SAME(a_ts_count, frame_busy_ff, bytes_taken_ff <= TS_LAST_BYTE, "count past cap")
   `ITM_ASSERT_NEXT(a_ts_cap, ts_cap_fire, !frame_busy_ff, "timestamp frame open past cap")
   `ITM_ASSERT_SAME(a_exc_width, exc_out, rsp_ff.value[VALUE_W-1:9] == '0, "exception too wide")

endmodule

`default_nettype wire
